// ===== hdl/rtm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtm_pkg
// Shared types and constants for the range table membership/union block.
// ----------------------------------------------------------------------------
package rtm_pkg;

    localparam int MAX_RANGES = 256;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_NONE   = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic [63:0] item_id;
    } in_item_t;

    typedef struct packed {
        logic        in_range;
        logic [63:0] match_count;
        logic [63:0] covered_total;
        logic        status;
    } out_item_t;

    // Classified command passed from front to back.
    typedef struct packed {
        req_kind_t   kind;
        logic [63:0] key;
        logic [63:0] value;
    } cmd_t;

endpackage

// ===== hdl/range_table_membership_union.sv =====
// ----------------------------------------------------------------------------
// range_table_membership_union
// Sorted range table with insert, membership query and union-length report.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in      | in        | in_valid/in_stall| rtm_pkg::in_item_t
//  out     | out       | out_valid/out_stall | rtm_pkg::out_item_t
//
// Each item walks the table in the back end, taking each stored entry through
// memory read, register and compare (S_READ, S_WAIT, S_SCAN); an insert also
// moves each entry above it up through S_SHIFT, S_SHRD and S_DONE. The front queue
// holds two items so input is taken while the back end walks.
// Reset clears the entry count and hit count; the range memory is not reset.
// A finished result waits in the output register while out_stall is high.
module range_table_membership_union (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rtm_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rtm_pkg::out_item_t out_data
);

    logic          cmd_valid;
    logic          cmd_take;
    rtm_pkg::cmd_t cmd;

    rtm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    rtm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (out_data)
    );

    // A result held under stall keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // A command is only taken when one is offered.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("command taken from empty queue");

endmodule

// ===== hdl/rtm_front.sv =====
// ----------------------------------------------------------------------------
// rtm_front
// Accepts items, classifies the request and queues commands for the back end.
// ----------------------------------------------------------------------------
module rtm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rtm_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output rtm_pkg::cmd_t     cmd
);

    localparam int PW = $clog2(rtm_pkg::QUEUE_DEPTH);

    rtm_pkg::cmd_t  q_mem [rtm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]    fill_reg;
    rtm_pkg::cmd_t  cls;
    logic           push, pop;

    always_comb
    begin
        cls.kind  = rtm_pkg::req_kind_t'(in_data.req_type);
        cls.key   = in_data.range_start;
        cls.value = in_data.range_end;
        case (cls.kind)
            rtm_pkg::REQ_QUERY:
            begin
                cls.key = in_data.item_id;
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = (fill_reg == (PW+1)'(rtm_pkg::QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== hdl/rtm_back.sv =====
// ----------------------------------------------------------------------------
// rtm_back
// Walks the sorted range memory entry by entry to execute each command; no new command is taken until the walk ends.
// ----------------------------------------------------------------------------
module rtm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  rtm_pkg::cmd_t      cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output rtm_pkg::out_item_t res
);

    localparam int IW = rtm_pkg::IDX_W;
    localparam int CW = rtm_pkg::CNT_W;
    localparam logic [63:0] ALL_ONES = '1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_WAIT  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_SHRD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    logic [63:0] start_mem [rtm_pkg::MAX_RANGES];
    logic [63:0] end_mem   [rtm_pkg::MAX_RANGES];

    state_t        state_reg, state_next;
    rtm_pkg::cmd_t cmd_reg;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg;
    logic [63:0]   hit_reg;
    logic [63:0]   rd_s_reg, rd_e_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [63:0]   wr_s, wr_e;
    logic [CW-1:0] pos_reg;
    logic [63:0]   total_reg, cur_s_reg, cur_e_reg;
    logic          open_reg;
    logic          out_valid_reg;
    rtm_pkg::out_item_t out_reg;
    logic          fin;
    rtm_pkg::out_item_t fin_val;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_s_reg <= start_mem[rd_addr];
            rd_e_reg <= end_mem[rd_addr];
        end
        if (wr_en)
        begin
            start_mem[wr_addr] <= wr_s;
            end_mem[wr_addr]   <= wr_e;
        end
    end

    function automatic logic [63:0] add_span(input logic [63:0] tot,
                                             input logic [63:0] lo,
                                             input logic [63:0] hi);
        logic [63:0] lm1;
        logic [64:0] s;
        begin
            lm1 = hi - lo;
            s   = {1'b0, tot} + {1'b0, lm1} + 65'd1;
            if (lm1 == ALL_ONES || s[64])
            begin
                add_span = ALL_ONES;
            end
            else
            begin
                add_span = s[63:0];
            end
        end
    endfunction

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // combinational control of the walk
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        rd_en      = 1'b0;
        rd_addr    = k_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = k_reg[IW-1:0];
        wr_s       = rd_s_reg;
        wr_e       = rd_e_reg;
        fin        = 1'b0;
        fin_val    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd_reg.kind == rtm_pkg::REQ_NONE)
                begin
                    fin = 1'b1;
                end
                else if (k_reg >= count_reg)
                begin
                    // end of table
                    case (cmd_reg.kind)
                        rtm_pkg::REQ_INSERT:
                        begin
                            if (count_reg == CW'(rtm_pkg::MAX_RANGES))
                            begin
                                fin = 1'b1;
                                fin_val.status = 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = S_SHIFT;
                            end
                        end
                        rtm_pkg::REQ_REPORT:
                        begin
                            fin = 1'b1;
                            fin_val.match_count = hit_reg;
                            fin_val.covered_total = open_reg ?
                                add_span(total_reg, cur_s_reg, cur_e_reg) : total_reg;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                state_next = S_READ;
                k_next     = k_reg + 1'b1;
                case (cmd_reg.kind)
                    rtm_pkg::REQ_INSERT:
                    begin
                        if (rd_s_reg == cmd_reg.key)
                        begin
                            fin = 1'b1;
                            if (cmd_reg.value > rd_e_reg)
                            begin
                                wr_en = 1'b1;
                                wr_e  = cmd_reg.value;
                            end
                        end
                        else if (rd_s_reg > cmd_reg.key)
                        begin
                            if (count_reg == CW'(rtm_pkg::MAX_RANGES))
                            begin
                                fin = 1'b1;
                                fin_val.status = 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    rtm_pkg::REQ_QUERY:
                    begin
                        if (rd_s_reg > cmd_reg.key)
                        begin
                            fin = 1'b1;
                        end
                        else if (cmd_reg.key <= rd_e_reg)
                        begin
                            fin = 1'b1;
                            fin_val.in_range = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHIFT:
            begin
                // k is the slot to fill; move k-1 up or place the new range
                if (k_reg == pos_reg)
                begin
                    wr_en = 1'b1;
                    wr_s  = cmd_reg.key;
                    wr_e  = cmd_reg.value;
                    fin   = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(k_reg - 1'b1);
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                wr_en      = 1'b1;
                state_next = S_SHIFT;
                k_next     = k_reg - 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            count_reg     <= '0;
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
            open_reg      <= 1'b0;
            total_reg     <= '0;
            pos_reg       <= '0;
            cmd_reg       <= '0;
            cur_s_reg     <= '0;
            cur_e_reg     <= '0;
        end
        else
        begin
            // result slot: the walk holds in S_IDLE-bound finish until it is free
            if (fin && !(out_valid_reg && res_stall))
            begin
                state_reg     <= state_next;
                k_reg         <= k_next;
                out_valid_reg <= 1'b1;
                if (cmd_reg.kind == rtm_pkg::REQ_QUERY && fin_val.in_range
                    && hit_reg != ALL_ONES)
                begin
                    hit_reg <= hit_reg + 64'd1;
                end
                if (state_reg == S_SHIFT)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else
            begin
                if (!fin)
                begin
                    state_reg <= state_next;
                    k_reg     <= k_next;
                end
                if (out_valid_reg && !res_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            if (state_reg == S_IDLE && cmd_valid)
            begin
                cmd_reg   <= cmd;
                open_reg  <= 1'b0;
                total_reg <= '0;
                cur_s_reg <= '0;
                cur_e_reg <= '0;
            end
            if (state_reg == S_SCAN)
            begin
                pos_reg <= k_reg;
                if (cmd_reg.kind == rtm_pkg::REQ_REPORT && rd_e_reg >= rd_s_reg)
                begin
                    if (open_reg && rd_s_reg <= cur_e_reg)
                    begin
                        if (rd_e_reg > cur_e_reg)
                        begin
                            cur_e_reg <= rd_e_reg;
                        end
                    end
                    else
                    begin
                        if (open_reg)
                        begin
                            total_reg <= add_span(total_reg, cur_s_reg, cur_e_reg);
                        end
                        cur_s_reg <= rd_s_reg;
                        cur_e_reg <= rd_e_reg;
                        open_reg  <= 1'b1;
                    end
                end
            end
            if (state_reg == S_READ && k_reg >= count_reg)
            begin
                pos_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin && !(out_valid_reg && res_stall))
        begin
            out_reg <= fin_val;
        end
    end

endmodule
